### hw/rtl/tbc_pkg.sv
// Shared widths and types for the triangle barycentric weight pipeline.
`default_nettype none
package tbc_pkg;
    localparam int COORD_W  = 18;
    localparam int FRAC_W   = 24;
    localparam int WEIGHT_W = 32;
    localparam int NUM_IN   = 12;
    localparam int IN_W     = ((NUM_IN * COORD_W + 7) / 8) * 8;
    localparam int OUT_W    = 3 * WEIGHT_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int LO_W     = (CROSS_W + 1) / 2;
    localparam int HI_W     = CROSS_W - LO_W;
    localparam int PART_W   = CROSS_W + 1;
    localparam int MUL_W    = 2 * CROSS_W;
    localparam int DOT_W    = MUL_W + 2;
    localparam int NUM_W    = DOT_W + FRAC_W + 2;
    localparam int DIV_W    = DOT_W + 1;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [CROSS_W-1:0]  cross_t;
    typedef logic signed [PART_W-1:0]   part_t;
    typedef logic signed [MUL_W-1:0]    mul_t;
    typedef logic signed [DOT_W-1:0]    dot_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
endpackage
`default_nettype wire

### hw/rtl/tbc_cross.sv
// Edge differences and the four cross products (normal and sub-triangle normals).
`default_nettype none
module tbc_cross (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tbc_pkg::coord_t [2:0]          pt,
    input  tbc_pkg::coord_t [2:0]          va,
    input  tbc_pkg::coord_t [2:0]          vb,
    input  tbc_pkg::coord_t [2:0]          vc,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tbc_pkg::cross_t [3:0][2:0]     crs
);
    import tbc_pkg::*;

    function automatic diff_t sub_c(input coord_t x, input coord_t y);
        return diff_t'(x) - diff_t'(y);
    endfunction

    logic [2:0] v_reg;
    logic [3:0] adv;

    // cross k is u[k] x w[k]: n, sub-normal a, sub-normal b, sub-normal c
    diff_t  u_next [4][3];
    diff_t  w_next [4][3];
    diff_t  u_reg  [4][3];
    diff_t  w_reg  [4][3];
    prod_t  prod_reg [4][3][2];
    cross_t crs_reg  [4][3];

    assign adv[3]    = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = v_reg[2];

    generate
        for (genvar i = 0; i < 3; i++) begin : g_adv
            assign adv[i] = !v_reg[i] || adv[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            u_next[0][j] = sub_c(vb[j], va[j]);
            w_next[0][j] = sub_c(vc[j], va[j]);
            u_next[1][j] = sub_c(vc[j], vb[j]);
            w_next[1][j] = sub_c(pt[j], vb[j]);
            u_next[2][j] = sub_c(va[j], vc[j]);
            w_next[2][j] = sub_c(pt[j], vc[j]);
            u_next[3][j] = sub_c(vb[j], va[j]);
            w_next[3][j] = sub_c(pt[j], va[j]);
        end
    end

    generate
        for (genvar k = 0; k < 4; k++) begin : g_k
            for (genvar j = 0; j < 3; j++) begin : g_j
                localparam int A1 = (j + 1) % 3;
                localparam int A2 = (j + 2) % 3;
                always_ff @(posedge clk)
                begin
                    if (adv[0])
                    begin
                        u_reg[k][j] <= u_next[k][j];
                        w_reg[k][j] <= w_next[k][j];
                    end
                    if (adv[1])
                    begin
                        prod_reg[k][j][0] <= prod_t'(u_reg[k][A1]) * prod_t'(w_reg[k][A2]);
                        prod_reg[k][j][1] <= prod_t'(u_reg[k][A2]) * prod_t'(w_reg[k][A1]);
                    end
                    if (adv[2])
                    begin
                        crs_reg[k][j] <= cross_t'(prod_reg[k][j][0])
                                       - cross_t'(prod_reg[k][j][1]);
                    end
                end
                assign crs[k][j] = crs_reg[k][j];
            end
        end
    endgenerate
endmodule
`default_nettype wire

### hw/rtl/tbc_dot.sv
// Four dot products with the normal, each 39x39 product split into four partials.
`default_nettype none
module tbc_dot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tbc_pkg::cross_t [3:0][2:0]     crs,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tbc_pkg::dot_t [3:0]            dots
);
    import tbc_pkg::*;

    logic [2:0] v_reg;
    logic [3:0] adv;

    logic [2*LO_W-1:0] ll_reg [4][3];
    part_t             hl_reg [4][3];
    part_t             lh_reg [4][3];
    part_t             hh_reg [4][3];
    mul_t              mul_reg [4][3];
    dot_t              dot_reg [4];

    assign adv[3]    = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = v_reg[2];

    generate
        for (genvar i = 0; i < 3; i++) begin : g_adv
            assign adv[i] = !v_reg[i] || adv[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
        end
    end

    generate
        for (genvar k = 0; k < 4; k++) begin : g_k
            for (genvar j = 0; j < 3; j++) begin : g_j
                cross_t                  a;
                cross_t                  b;
                logic [LO_W-1:0]         al;
                logic [LO_W-1:0]         bl;
                logic signed [HI_W-1:0]  ah;
                logic signed [HI_W-1:0]  bh;
                assign a  = crs[0][j];
                assign b  = crs[k][j];
                assign al = a[LO_W-1:0];
                assign bl = b[LO_W-1:0];
                assign ah = a[CROSS_W-1:LO_W];
                assign bh = b[CROSS_W-1:LO_W];
                always_ff @(posedge clk)
                begin
                    if (adv[0])
                    begin
                        ll_reg[k][j] <= {{LO_W{1'b0}}, al} * {{LO_W{1'b0}}, bl};
                        hl_reg[k][j] <= part_t'(ah) * part_t'($signed({1'b0, bl}));
                        lh_reg[k][j] <= part_t'($signed({1'b0, al})) * part_t'(bh);
                        hh_reg[k][j] <= part_t'(ah) * part_t'(bh);
                    end
                    if (adv[1])
                    begin
                        mul_reg[k][j] <= (mul_t'(hh_reg[k][j]) <<< (2 * LO_W))
                                       + ((mul_t'(hl_reg[k][j]) + mul_t'(lh_reg[k][j]))
                                          <<< LO_W)
                                       + mul_t'(ll_reg[k][j]);
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv[2])
                begin
                    dot_reg[k] <= dot_t'(mul_reg[k][0]) + dot_t'(mul_reg[k][1])
                                + dot_t'(mul_reg[k][2]);
                end
            end
            assign dots[k] = dot_reg[k];
        end
    endgenerate
endmodule
`default_nettype wire

### hw/rtl/tbc_div.sv
// Rounded, saturated ratios num/den: prep stage, one quotient bit per stage, final clamp.
`default_nettype none
module tbc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tbc_pkg::dot_t [3:0]            dots,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tbc_pkg::weight_t [2:0]         wgt,
    output logic                           degen
);
    import tbc_pkg::*;

    localparam int NS = WEIGHT_W + 2;   // prep, quotient bits, clamp

    logic [NS-1:0] v_reg;
    logic [NS:0]   adv;

    logic [DIV_W-1:0]    d_reg   [0:WEIGHT_W];
    logic                deg_reg [0:WEIGHT_W];
    logic [DIV_W-1:0]    rem_reg [0:WEIGHT_W][3];
    logic [WEIGHT_W-1:0] low_reg [0:WEIGHT_W][3];
    logic [WEIGHT_W-1:0] q_reg   [0:WEIGHT_W][3];
    logic                neg_reg [0:WEIGHT_W][3];
    logic                big_reg [0:WEIGHT_W][3];

    logic [DIV_W-1:0]    d0;
    logic [DIV_W-1:0]    rem0  [3];
    logic [WEIGHT_W-1:0] low0  [3];
    logic                neg0  [3];
    logic                big0  [3];
    logic [DIV_W-1:0]    rem_next [1:WEIGHT_W][3];
    logic                bit_next [1:WEIGHT_W][3];
    weight_t             w_next [3];
    weight_t             w_reg  [3];
    logic                deg_out_reg;

    assign adv[NS]   = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];

    generate
        for (genvar i = 0; i < NS; i++) begin : g_adv
            assign adv[i] = !v_reg[i] || adv[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s]) v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // prep: N = |num| * 2^(F+1) + den, D = 2*den, q = floor(N / D)
    always_comb
    begin
        dot_t             num;
        logic [DOT_W-1:0] mag;
        logic [NUM_W-1:0] nn;
        d0 = {dots[0], 1'b0};
        for (int l = 0; l < 3; l++)
        begin
            num     = dots[l+1];
            neg0[l] = num[DOT_W-1];
            mag     = neg0[l] ? DOT_W'(-num) : DOT_W'(num);
            nn      = (NUM_W'(mag) << (FRAC_W + 1)) + NUM_W'(dots[0]);
            rem0[l] = DIV_W'(nn[NUM_W-1:WEIGHT_W]);
            low0[l] = nn[WEIGHT_W-1:0];
            big0[l] = rem0[l] >= d0;
        end
    end

    // restoring step, remainder stays below D
    always_comb
    begin
        logic [DIV_W:0] t;
        logic [DIV_W:0] df;
        for (int s = 1; s <= WEIGHT_W; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                t = {rem_reg[s-1][l], low_reg[s-1][l][WEIGHT_W-1]};
                df = t - {1'b0, d_reg[s-1]};
                bit_next[s][l] = t >= {1'b0, d_reg[s-1]};
                rem_next[s][l] = bit_next[s][l] ? df[DIV_W-1:0] : t[DIV_W-1:0];
            end
        end
    end

    always_comb
    begin
        logic [WEIGHT_W-1:0] lim;
        logic [WEIGHT_W-1:0] qs;
        for (int l = 0; l < 3; l++)
        begin
            lim = neg_reg[WEIGHT_W][l] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                       : {1'b0, {(WEIGHT_W-1){1'b1}}};
            qs  = (big_reg[WEIGHT_W][l] || q_reg[WEIGHT_W][l] > lim) ? lim
                                                                     : q_reg[WEIGHT_W][l];
            if (deg_reg[WEIGHT_W])
                w_next[l] = '0;
            else
                w_next[l] = neg_reg[WEIGHT_W][l] ? weight_t'(-qs) : weight_t'(qs);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d_reg[0]   <= d0;
            deg_reg[0] <= (dots[0] == '0);
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= rem0[l];
                low_reg[0][l] <= low0[l];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= neg0[l];
                big_reg[0][l] <= big0[l];
            end
        end
        for (int s = 1; s <= WEIGHT_W; s++)
        begin
            if (adv[s])
            begin
                d_reg[s]   <= d_reg[s-1];
                deg_reg[s] <= deg_reg[s-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    low_reg[s][l] <= {low_reg[s-1][l][WEIGHT_W-2:0], 1'b0};
                    q_reg[s][l]   <= {q_reg[s-1][l][WEIGHT_W-2:0], bit_next[s][l]};
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    big_reg[s][l] <= big_reg[s-1][l];
                end
            end
        end
        if (adv[NS-1])
        begin
            deg_out_reg <= deg_reg[WEIGHT_W];
            for (int l = 0; l < 3; l++)
            begin
                w_reg[l] <= w_next[l];
            end
        end
    end

    assign degen = deg_out_reg;
    generate
        for (genvar l = 0; l < 3; l++) begin : g_out
            assign wgt[l] = w_reg[l];
        end
    endgenerate
endmodule
`default_nettype wire

### hw/rtl/triangle_barycentric_coords_3d.sv
// Top level of the triangle barycentric weight pipeline.
`default_nettype none
// Streams one query point plus triangle (a, b, c) per beat and returns the three
// barycentric weights of the point in signed Q8.24, rounded to nearest (ties away
// from zero) and saturated to 32 bits. A point off the plane gets the weights of
// its projection. If the triangle has zero area the degenerate flag in tuser is
// set and all weights are zero. The pipeline takes one beat every cycle while the
// output is not stalled. Its register stages cover differences and cross products,
// the split 39x39 dot products, and the divider, whose 32 quotient bits each take
// their own register stage. Every stage moves on its own when the next one has
// room, so bubbles are squeezed out and a stalled output holds without loss.
module triangle_barycentric_coords_3d (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // point_x, point_y, point_z, vert_a_x/y/z, vert_b_x/y/z, vert_c_x/y/z
    input  logic [tbc_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // weight_a, weight_b, weight_c
    output logic [tbc_pkg::OUT_W-1:0]  m_axis_tdata,
    // degenerate
    output logic [0:0]                 m_axis_tuser
);
    import tbc_pkg::*;

    coord_t [2:0]      pt;
    coord_t [2:0]      va;
    coord_t [2:0]      vb;
    coord_t [2:0]      vc;
    cross_t [3:0][2:0] crs;
    dot_t   [3:0]      dots;
    weight_t [2:0]     wgt;
    logic              cr_valid;
    logic              cr_ready;
    logic              dt_valid;
    logic              dt_ready;
    logic              degen;

    // input beat unpacking, first field in the low bits
    generate
        for (genvar j = 0; j < 3; j++) begin : g_unpack
            assign pt[j] = s_axis_tdata[(j)*COORD_W +: COORD_W];
            assign va[j] = s_axis_tdata[(3+j)*COORD_W +: COORD_W];
            assign vb[j] = s_axis_tdata[(6+j)*COORD_W +: COORD_W];
            assign vc[j] = s_axis_tdata[(9+j)*COORD_W +: COORD_W];
        end
    endgenerate

    // n = ab x ac and sub-triangle normals
    tbc_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pt        (pt),
        .va        (va),
        .vb        (vb),
        .vc        (vc),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .crs       (crs)
    );

    // dots[0] = n.n (denominator), dots[1..3] = n . sub-normal
    tbc_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (cr_ready),
        .crs       (crs),
        .out_valid (dt_valid),
        .out_ready (dt_ready),
        .dots      (dots)
    );

    // bit-per-stage divider, last stage is the output register
    tbc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dt_valid),
        .in_ready  (dt_ready),
        .dots      (dots),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .wgt       (wgt),
        .degen     (degen)
    );

    assign m_axis_tdata = {wgt[2], wgt[1], wgt[0]};
    assign m_axis_tuser = degen;

    // a degenerate triangle never carries nonzero weights
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate beat with nonzero weights");

    // input backpressure only when the whole pipe is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while pipeline has room");

    // a beat held at the output with no room must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled output beat changed");
endmodule
`default_nettype wire
